// ===== rtl/sm4_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and round functions for the SM4 encryption pipeline.
package sm4_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int CFG_IDX_W   = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3 = 8'd3;

    localparam logic [3:0][31:0] FK = {32'hB27022DC, 32'h677D9197,
                                       32'h56AA3350, 32'hA3B1BAC6};

    typedef struct packed {
        logic [31:0] plain_word0;
        logic [31:0] plain_word1;
        logic [31:0] plain_word2;
        logic [31:0] plain_word3;
    } t_plain;

    typedef struct packed {
        logic [31:0] cipher_word0;
        logic [31:0] cipher_word1;
        logic [31:0] cipher_word2;
        logic [31:0] cipher_word3;
    } t_cipher;

    // Key schedule words and data words carried by every pipeline stage
    typedef struct packed {
        logic [3:0][31:0] k;
        logic [3:0][31:0] x;
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
        8'd214, 8'd144, 8'd233, 8'd254, 8'd204, 8'd225, 8'd61, 8'd183,
        8'd22, 8'd182, 8'd20, 8'd194, 8'd40, 8'd251, 8'd44, 8'd5,
        8'd43, 8'd103, 8'd154, 8'd118, 8'd42, 8'd190, 8'd4, 8'd195,
        8'd170, 8'd68, 8'd19, 8'd38, 8'd73, 8'd134, 8'd6, 8'd153,
        8'd156, 8'd66, 8'd80, 8'd244, 8'd145, 8'd239, 8'd152, 8'd122,
        8'd51, 8'd84, 8'd11, 8'd67, 8'd237, 8'd207, 8'd172, 8'd98,
        8'd228, 8'd179, 8'd28, 8'd169, 8'd201, 8'd8, 8'd232, 8'd149,
        8'd128, 8'd223, 8'd148, 8'd250, 8'd117, 8'd143, 8'd63, 8'd166,
        8'd71, 8'd7, 8'd167, 8'd252, 8'd243, 8'd115, 8'd23, 8'd186,
        8'd131, 8'd89, 8'd60, 8'd25, 8'd230, 8'd133, 8'd79, 8'd168,
        8'd104, 8'd107, 8'd129, 8'd178, 8'd113, 8'd100, 8'd218, 8'd139,
        8'd248, 8'd235, 8'd15, 8'd75, 8'd112, 8'd86, 8'd157, 8'd53,
        8'd30, 8'd36, 8'd14, 8'd94, 8'd99, 8'd88, 8'd209, 8'd162,
        8'd37, 8'd34, 8'd124, 8'd59, 8'd1, 8'd33, 8'd120, 8'd135,
        8'd212, 8'd0, 8'd70, 8'd87, 8'd159, 8'd211, 8'd39, 8'd82,
        8'd76, 8'd54, 8'd2, 8'd231, 8'd160, 8'd196, 8'd200, 8'd158,
        8'd234, 8'd191, 8'd138, 8'd210, 8'd64, 8'd199, 8'd56, 8'd181,
        8'd163, 8'd247, 8'd242, 8'd206, 8'd249, 8'd97, 8'd21, 8'd161,
        8'd224, 8'd174, 8'd93, 8'd164, 8'd155, 8'd52, 8'd26, 8'd85,
        8'd173, 8'd147, 8'd50, 8'd48, 8'd245, 8'd140, 8'd177, 8'd227,
        8'd29, 8'd246, 8'd226, 8'd46, 8'd130, 8'd102, 8'd202, 8'd96,
        8'd192, 8'd41, 8'd35, 8'd171, 8'd13, 8'd83, 8'd78, 8'd111,
        8'd213, 8'd219, 8'd55, 8'd69, 8'd222, 8'd253, 8'd142, 8'd47,
        8'd3, 8'd255, 8'd106, 8'd114, 8'd109, 8'd108, 8'd91, 8'd81,
        8'd141, 8'd27, 8'd175, 8'd146, 8'd187, 8'd221, 8'd188, 8'd127,
        8'd17, 8'd217, 8'd92, 8'd65, 8'd31, 8'd16, 8'd90, 8'd216,
        8'd10, 8'd193, 8'd49, 8'd136, 8'd165, 8'd205, 8'd123, 8'd189,
        8'd45, 8'd116, 8'd208, 8'd18, 8'd184, 8'd229, 8'd180, 8'd176,
        8'd137, 8'd105, 8'd151, 8'd74, 8'd12, 8'd150, 8'd119, 8'd126,
        8'd101, 8'd185, 8'd241, 8'd9, 8'd197, 8'd110, 8'd198, 8'd132,
        8'd24, 8'd240, 8'd125, 8'd236, 8'd58, 8'd220, 8'd77, 8'd32,
        8'd121, 8'd238, 8'd95, 8'd62, 8'd215, 8'd203, 8'd57, 8'd72
    };

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        sub_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // L' of the key schedule: rotations by 13 and 23
    function automatic logic [31:0] lin_key(input logic [31:0] b);
        lin_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    // L of the data path: rotations by 2, 10, 18 and 24
    function automatic logic [31:0] lin_data(input logic [31:0] t);
        lin_data = t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]}
                     ^ {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};
    endfunction

    // CK_i: byte j (from the top) is (4i+j)*7 mod 256
    function automatic logic [31:0] round_const(input int i);
        logic [31:0] c;
        c = '0;
        for (int j = 0; j < 4; j++) begin
            c = {c[23:0], 8'((4 * i + j) * 7)};
        end
        round_const = c;
    endfunction

endpackage

// ===== rtl/sm4_round.sv =====
`timescale 1ns / 1ps
// One pipeline stage: derive the round key and apply one data round.
module sm4_round (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [31:0]     i_ck,
    input  sm4_pkg::t_state i_state,
    output logic            o_valid,
    output sm4_pkg::t_state o_state
);
    import sm4_pkg::*;

    logic   [31:0] key_mix;
    logic   [31:0] rk;
    logic   [31:0] data_mix;
    logic   [31:0] nx;
    t_state        n_state;
    t_state        r_state;
    logic          r_valid;

    always_comb begin
        key_mix  = sub_word(i_state.k[1] ^ i_state.k[2] ^ i_state.k[3] ^ i_ck);
        rk       = i_state.k[0] ^ lin_key(key_mix);
        data_mix = sub_word(i_state.x[1] ^ i_state.x[2] ^ i_state.x[3] ^ rk);
        nx       = i_state.x[0] ^ lin_data(data_mix);

        // shift both windows down one word
        n_state.k = {rk, i_state.k[3], i_state.k[2], i_state.k[1]};
        n_state.x = {nx, i_state.x[3], i_state.x[2], i_state.x[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // hold payload while the stage carries no request
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

// ===== rtl/sm4_block_encrypt.sv =====
`timescale 1ns / 1ps
// Top level of the SM4 block encryption pipeline: key registers, entry stage, rounds.
// Data path: a request is loaded into the entry register when it is taken, then passes
//   through the registered round stages and shows its result on o_cipher with o_done.
// Throughput: one request per cycle; busy stays low, so start may be high every cycle.
// The receiver cannot stall: each result is valid for exactly the o_done cycle.
// Reset (synchronous, active low) clears all stage valid bits and the key registers.
module sm4_block_encrypt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           start,
    output logic                           busy,
    input  sm4_pkg::t_plain                i_plain,
    // result channel
    output logic                           o_done,
    output sm4_pkg::t_cipher               o_cipher,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sm4_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import sm4_pkg::*;

    // Cipher key words; the user must write them only while no request is in flight (not enforced here)
    logic [3:0][31:0] r_key;

    // Entry stage: plaintext and key XOR FK
    logic    r_entry_valid;
    t_state  r_entry;
    t_state  n_entry;

    // Stage links: index 0 is the entry stage, index r+1 the output of round r
    logic   [ROUND_COUNT:0] stage_valid;
    t_state                 stage_state [ROUND_COUNT+1];

    logic                   accept;

    // The pipeline never stalls, so a request is always taken
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Config writes; indexes beyond the key words are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_WORD0: r_key[0] <= i_cfg_data;
                CFG_KEY_WORD1: r_key[1] <= i_cfg_data;
                CFG_KEY_WORD2: r_key[2] <= i_cfg_data;
                CFG_KEY_WORD3: r_key[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Load the plaintext words X0..X3 and the whitened key K0..K3
    always_comb begin
        n_entry.x = {i_plain.plain_word3, i_plain.plain_word2,
                     i_plain.plain_word1, i_plain.plain_word0};
        n_entry.k = r_key ^ FK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= 1'b0;
        end else begin
            r_entry_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

    assign stage_valid[0] = r_entry_valid;
    assign stage_state[0] = r_entry;

    // One registered stage per round; each computes its own round key, so the
    // key schedule travels down the pipeline alongside the data
    for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
        sm4_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[r]),
            .i_ck    (round_const(r)),
            .i_state (stage_state[r]),
            .o_valid (stage_valid[r+1]),
            .o_state (stage_state[r+1])
        );
    end

    // The last stage register drives the ports directly; output words are
    // the final window in reversed order (X35, X34, X33, X32)
    assign o_done                = stage_valid[ROUND_COUNT];
    assign o_cipher.cipher_word0 = stage_state[ROUND_COUNT].x[3];
    assign o_cipher.cipher_word1 = stage_state[ROUND_COUNT].x[2];
    assign o_cipher.cipher_word2 = stage_state[ROUND_COUNT].x[1];
    assign o_cipher.cipher_word3 = stage_state[ROUND_COUNT].x[0];

endmodule
